FILE: design/elfc_pkg.sv
// Package for the ELF32 image checker: verdict codes, header layout constants,
// the scan summary struct and the magic-byte lookup.
// No dependencies; imported by every module of the block.
package elfc_pkg;

  localparam int EHDR_SIZE = 52;
  localparam int PHDR_SIZE = 32;
  localparam int CNT_W     = 33;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Header byte positions that carry a check or a capture
  localparam logic [5:0] POS_CLASS     = 6'd4;
  localparam logic [5:0] POS_ORDER     = 6'd5;
  localparam logic [5:0] POS_TYPE_HI   = 6'd17;
  localparam logic [5:0] POS_MACH_HI   = 6'd19;
  localparam logic [5:0] POS_PHOFF_HI  = 6'd31;
  localparam logic [5:0] POS_PHENT_HI  = 6'd43;
  localparam logic [5:0] POS_PHNUM_HI  = 6'd45;
  localparam logic [5:0] POS_HDR_LAST  = 6'd51;

  localparam logic [7:0]  CLASS_32   = 8'd1;
  localparam logic [7:0]  ORDER_LSB  = 8'd1;
  localparam logic [15:0] TYPE_EXEC  = 16'd2;
  localparam logic [15:0] MACH_MIPS  = 16'd8;
  localparam logic [31:0] PT_LOAD    = 32'd1;

  // Byte positions inside one program-header entry
  localparam logic [15:0] ENT_TYPE_LO   = 16'd0;
  localparam logic [15:0] ENT_OFFSET_LO = 16'd4;
  localparam logic [15:0] ENT_OFFSET_HI = 16'd8;
  localparam logic [15:0] ENT_FSIZE_LO  = 16'd16;
  localparam logic [15:0] ENT_FSIZE_HI  = 16'd19;

  typedef enum logic [3:0] {
    FAIL_NONE        = 4'd0,
    FAIL_SHORT       = 4'd1,
    FAIL_MAGIC       = 4'd2,
    FAIL_CLASS       = 4'd3,
    FAIL_ORDER       = 4'd4,
    FAIL_TYPE        = 4'd5,
    FAIL_MACHINE     = 4'd6,
    FAIL_TABLE_SHAPE = 4'd7,
    FAIL_OVERLAP     = 4'd8,
    FAIL_TABLE_END   = 4'd9,
    FAIL_SEGMENT_END = 4'd10,
    FAIL_NO_LOAD     = 4'd11
  } fail_t;

  // State after the byte in flight, as the verdict needs it
  typedef struct packed {
    logic [CNT_W-1:0] count_next;
    fail_t            fail_next;
    logic [CNT_W-1:0] table_end;
    logic [CNT_W-1:0] max_end;
    logic             seg_hit;
    logic [CNT_W-1:0] seg_end;
    logic             load_next;
  } summary_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0:    res = 8'h7F;
      2'd1:    res = 8'h45;
      2'd2:    res = 8'h4C;
      default: res = 8'h46;
    endcase
    return res;
  endfunction

endpackage

FILE: design/elfc_scan.sv
// Byte scanner of the ELF32 image checker: header checks, table walk and
// segment tracking, one byte per step. Depends on elfc_pkg.
module elfc_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output elfc_pkg::summary_t summary
);
  import elfc_pkg::*;

  logic [CNT_W-1:0] count, count_next;
  fail_t            first_fail, first_fail_next;
  logic [31:0]      hfb, hfb_next;
  logic [31:0]      table_offset, table_offset_next;
  logic [15:0]      entry_size, entry_size_next;
  logic [15:0]      entry_count, entry_count_next;
  logic [15:0]      entries_seen, entries_seen_next;
  logic [CNT_W-1:0] next_start, next_start_next;
  logic [15:0]      ebi, ebi_next;
  logic [31:0]      fld_type, fld_type_next;
  logic [31:0]      fld_offset, fld_offset_next;
  logic [31:0]      fld_size, fld_size_next;
  logic [CNT_W-1:0] max_end, max_end_next;
  logic             load_seen, load_seen_next;
  logic [31:0]      product;
  logic [CNT_W-1:0] table_end;

  logic [31:0]      hfb_shift;
  logic [31:0]      lane;
  logic [5:0]       hdr_pos;
  logic             in_header;
  logic             tbl_active;
  fail_t            hdr_fail;
  logic             seg_hit;
  logic [CNT_W-1:0] seg_end;

  assign hdr_pos    = count[5:0];
  assign in_header  = count < CNT_W'(EHDR_SIZE);
  assign tbl_active = (first_fail == FAIL_NONE) && (entries_seen < entry_count) &&
                      (count >= next_start);
  assign hfb_shift  = {data_byte, hfb[31:8]};
  assign lane       = 32'(data_byte) << {ebi[1:0], 3'b000};

  always_comb begin
    count_next        = count;
    first_fail_next   = first_fail;
    hfb_next          = hfb;
    table_offset_next = table_offset;
    entry_size_next   = entry_size;
    entry_count_next  = entry_count;
    entries_seen_next = entries_seen;
    next_start_next   = next_start;
    ebi_next          = ebi;
    fld_type_next     = fld_type;
    fld_offset_next   = fld_offset;
    fld_size_next     = fld_size;
    max_end_next      = max_end;
    load_seen_next    = load_seen;
    hdr_fail          = FAIL_NONE;
    seg_hit           = 1'b0;
    seg_end           = {1'b0, fld_offset} + {1'b0, fld_size};

    if (step && (count != COUNT_MAX)) begin
      count_next = count + CNT_W'(1);
      if (in_header) begin
        hfb_next = hfb_shift;
        if (hdr_pos < POS_CLASS) begin
          if (data_byte != magic_byte(hdr_pos[1:0])) hdr_fail = FAIL_MAGIC;
        end else begin
          case (hdr_pos)
            POS_CLASS:    if (data_byte != CLASS_32) hdr_fail = FAIL_CLASS;
            POS_ORDER:    if (data_byte != ORDER_LSB) hdr_fail = FAIL_ORDER;
            POS_TYPE_HI:  if (hfb_shift[31:16] != TYPE_EXEC) hdr_fail = FAIL_TYPE;
            POS_MACH_HI:  if (hfb_shift[31:16] != MACH_MIPS) hdr_fail = FAIL_MACHINE;
            POS_PHOFF_HI: table_offset_next = hfb_shift;
            POS_PHENT_HI: entry_size_next = hfb_shift[31:16];
            POS_PHNUM_HI: entry_count_next = hfb_shift[31:16];
            POS_HDR_LAST: begin
              if (entry_count == 16'd0 || entry_size < 16'(PHDR_SIZE)) begin
                hdr_fail = FAIL_TABLE_SHAPE;
              end else if (table_offset < 32'(EHDR_SIZE)) begin
                hdr_fail = FAIL_OVERLAP;
              end
              next_start_next   = {1'b0, table_offset};
              entries_seen_next = 16'd0;
              ebi_next          = 16'd0;
            end
            default: ;
          endcase
        end
      end else if (tbl_active) begin
        if (ebi < ENT_OFFSET_LO) begin
          fld_type_next = (ebi == ENT_TYPE_LO) ? 32'(data_byte) : (fld_type | lane);
        end else if (ebi < ENT_OFFSET_HI) begin
          fld_offset_next = (ebi == ENT_OFFSET_LO) ? 32'(data_byte) : (fld_offset | lane);
        end else if (ebi >= ENT_FSIZE_LO && ebi <= ENT_FSIZE_HI) begin
          fld_size_next = (ebi == ENT_FSIZE_LO) ? 32'(data_byte) : (fld_size | lane);
        end
        seg_end = {1'b0, fld_offset} + {1'b0, fld_size_next};
        if (ebi == ENT_FSIZE_HI && fld_type == PT_LOAD) begin
          seg_hit        = 1'b1;
          load_seen_next = 1'b1;
          if (seg_end > max_end) max_end_next = seg_end;
        end
        // close the entry once its declared size has gone past
        if (({1'b0, ebi} + 17'd1) >= {1'b0, entry_size}) begin
          entries_seen_next = entries_seen + 16'd1;
          next_start_next   = next_start + {17'd0, entry_size};
          ebi_next          = 16'd0;
        end else begin
          ebi_next = ebi + 16'd1;
        end
      end
      if (first_fail == FAIL_NONE) first_fail_next = hdr_fail;
    end
  end

  // Table end is settled long before the header ends, so precompute it
  always_ff @(posedge clk) begin
    product   <= entry_size * entry_count;
    table_end <= {1'b0, table_offset} + {1'b0, product};
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      count        <= '0;
      first_fail   <= FAIL_NONE;
      hfb          <= '0;
      table_offset <= '0;
      entry_size   <= '0;
      entry_count  <= '0;
      entries_seen <= '0;
      next_start   <= '0;
      ebi          <= '0;
      fld_type     <= '0;
      fld_offset   <= '0;
      fld_size     <= '0;
      max_end      <= '0;
      load_seen    <= 1'b0;
    end else begin
      count        <= count_next;
      first_fail   <= first_fail_next;
      hfb          <= hfb_next;
      table_offset <= table_offset_next;
      entry_size   <= entry_size_next;
      entry_count  <= entry_count_next;
      entries_seen <= entries_seen_next;
      next_start   <= next_start_next;
      ebi          <= ebi_next;
      fld_type     <= fld_type_next;
      fld_offset   <= fld_offset_next;
      fld_size     <= fld_size_next;
      max_end      <= max_end_next;
      load_seen    <= load_seen_next;
    end
  end

  assign summary.count_next = count_next;
  assign summary.fail_next  = first_fail_next;
  assign summary.table_end  = table_end;
  assign summary.max_end    = max_end;
  assign summary.seg_hit    = seg_hit;
  assign summary.seg_end    = seg_end;
  assign summary.load_next  = load_seen_next;

endmodule

FILE: design/elfc_verdict.sv
// Verdict logic of the ELF32 image checker: ranks the reasons and picks the
// first one that applies at the final byte. Depends on elfc_pkg.
module elfc_verdict (
  input  elfc_pkg::summary_t summary,
  output logic               image_valid,
  output elfc_pkg::fail_t    fail_reason
);
  import elfc_pkg::*;

  logic seg_over;

  // farthest load end is either the stored one or the entry closing now
  assign seg_over = (summary.max_end > summary.count_next) ||
                    (summary.seg_hit && (summary.seg_end > summary.count_next));

  always_comb begin
    if (summary.count_next < CNT_W'(EHDR_SIZE)) begin
      fail_reason = FAIL_SHORT;
    end else if (summary.fail_next != FAIL_NONE) begin
      fail_reason = summary.fail_next;
    end else if (summary.table_end > summary.count_next) begin
      fail_reason = FAIL_TABLE_END;
    end else if (seg_over) begin
      fail_reason = FAIL_SEGMENT_END;
    end else if (!summary.load_next) begin
      fail_reason = FAIL_NO_LOAD;
    end else begin
      fail_reason = FAIL_NONE;
    end
  end

  assign image_valid = (fail_reason == FAIL_NONE);

endmodule

FILE: design/elf32_image_checker.sv
// Top level of the ELF32 image checker: input register, byte scanner,
// verdict logic and result register. Depends on elfc_pkg, elfc_scan, elfc_verdict.

// Feed the image one byte per transfer in file order, with s_tlast on the final
// byte. The block takes one byte every clock cycle, except that a final byte
// waits while an earlier verdict still fills the result register. Each byte
// is held in the input register and then updates the scan state with compares,
// captures and additions. A single verdict transfer leaves on the master side,
// carrying the pass flag and the first failing reason. A verdict waiting for
// m_tready does not hold up the next image: bytes keep flowing until another
// final byte meets a full result register. After each verdict all scan state
// returns to its reset value, so images may follow each other directly. There
// is no clearing pass after reset. A program-header table that starts inside
// the 52-byte header is reported as an overlap, since a stream cannot seek back.
module elf32_image_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] image_valid, [4:1] fail_reason, [7:5] zero
);
  import elfc_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;

  logic       out_valid;
  logic       out_image_valid;
  fail_t      out_reason;

  summary_t   summary;
  logic       vd_valid;
  fail_t      vd_reason;

  // A non-final byte never needs the result register; a final one waits for it
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register: hold the byte until the scanner takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  elfc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .summary   (summary)
  );

  elfc_verdict u_verdict (
    .summary     (summary),
    .image_valid (vd_valid),
    .fail_reason (vd_reason)
  );

  // Result register: load on the final byte, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_image_valid <= vd_valid;
      out_reason      <= vd_reason;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_reason, out_image_valid};

  // A verdict only appears after a final byte was processed
  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance && in_last))
    else $error("verdict raised without a final byte");

  // Pass flag and reason must agree
  a_flag_matches_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == FAIL_NONE)))
    else $error("pass flag disagrees with reason");

  // A final byte must not be taken while a verdict is stuck in the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last && out_valid && !m_tready) |-> (!advance && !s_tready))
    else $error("final byte taken over a pending verdict");

  // Reason stays within the defined codes and padding stays zero
  a_reason_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[4:1] <= FAIL_NO_LOAD) && (m_tdata[7:5] == 3'b000)))
    else $error("reason code out of range");

endmodule
